// ===== rtl/rnti_ip_session_map_table_defines.svh =====
// Assertion macros shared by the session map table checker.
// Depends on nothing; included by the checker file only.
`ifndef RNTI_IP_SESSION_MAP_TABLE_DEFINES_SVH
`define RNTI_IP_SESSION_MAP_TABLE_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RISM_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define RISM_ASSERT(label, prop, msg) \
    `RISM_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== rtl/rism_pkg.sv =====
// Shared types and constants of the session map table.
// Used by rism_cell, rnti_ip_session_map_table and rism_checker.
package rism_pkg;

    localparam int TABLE_ENTRIES = 256;

    localparam int KIND_W   = 3;
    localparam int ID_W     = 16;
    localparam int ADDR_W   = 32;
    localparam int SES_W    = 8;
    localparam int STATUS_W = 3;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam kind_t KIND_STORE       = 3'd0;
    localparam kind_t KIND_LOOKUP_ADDR = 3'd1;
    localparam kind_t KIND_LOOKUP_ID   = 3'd2;
    localparam kind_t KIND_REMOVE      = 3'd3;
    localparam kind_t KIND_CLEAR       = 3'd4;

    localparam status_t ST_NEW     = 3'd0;
    localparam status_t ST_UPDATED = 3'd1;
    localparam status_t ST_FULL    = 3'd2;
    localparam status_t ST_FOUND   = 3'd3;
    localparam status_t ST_MISS    = 3'd4;
    localparam status_t ST_REMOVED = 3'd5;
    localparam status_t ST_CLEARED = 3'd6;

    // Command held steady and broadcast to every cell while a sweep runs.
    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   radio_id;
        logic [ADDR_W-1:0] address;
        logic [SES_W-1:0]  session;
    } cmd_t;

    // Token that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic              active;
        logic              found;
        logic              free_seen;
        logic [ADDR_W-1:0] data;
    } token_t;

    // End-of-sweep broadcast: drop pending marks, and write the pending slot on commit.
    typedef struct packed {
        logic done;
        logic commit;
    } fin_t;

endpackage

// ===== rtl/rism_cell.sv =====
// One table slot of the session map table with its stage of the search token.
// Depends on rism_pkg.
module rism_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  rism_pkg::cmd_t    cmd,
    input  rism_pkg::fin_t    fin,
    input  rism_pkg::token_t  tok_in,
    output rism_pkg::token_t  tok_out
);

    logic                        valid_reg, valid_next;
    logic                        pend_reg, pend_next;
    logic [rism_pkg::ID_W-1:0]   id_reg, id_next;
    logic [rism_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [rism_pkg::SES_W-1:0]  ses_reg, ses_next;
    rism_pkg::token_t            tok_reg, tok_next;
    logic                        id_hit;
    logic                        addr_hit;

    assign id_hit   = valid_reg && (id_reg == cmd.radio_id) && (ses_reg == cmd.session);
    assign addr_hit = valid_reg && (addr_reg == cmd.address) && (ses_reg == cmd.session);
    assign tok_out  = tok_reg;

    always_comb begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        id_next    = id_reg;
        addr_next  = addr_reg;
        ses_next   = ses_reg;
        tok_next   = tok_in;
        if (tok_in.active) begin
            case (cmd.kind)
                rism_pkg::KIND_STORE: begin
                    if (!tok_in.found && id_hit) begin
                        addr_next      = cmd.address;
                        tok_next.found = 1'b1;
                    end
                    // The first empty slot is reserved; it is written only if no match turns up.
                    if (!tok_in.free_seen && !valid_reg) begin
                        pend_next          = 1'b1;
                        tok_next.free_seen = 1'b1;
                    end
                end
                rism_pkg::KIND_LOOKUP_ADDR: begin
                    if (!tok_in.found && id_hit) begin
                        tok_next.found = 1'b1;
                        tok_next.data  = addr_reg;
                    end
                end
                rism_pkg::KIND_LOOKUP_ID: begin
                    if (!tok_in.found && addr_hit) begin
                        tok_next.found = 1'b1;
                        tok_next.data  = {{(rism_pkg::ADDR_W-rism_pkg::ID_W){1'b0}}, id_reg};
                    end
                end
                rism_pkg::KIND_REMOVE: begin
                    if (!tok_in.found && id_hit) begin
                        valid_next     = 1'b0;
                        tok_next.found = 1'b1;
                    end
                end
                rism_pkg::KIND_CLEAR: begin
                    valid_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (fin.done) begin
            pend_next = 1'b0;
            if (fin.commit && pend_reg) begin
                valid_next = 1'b1;
                id_next    = cmd.radio_id;
                addr_next  = cmd.address;
                ses_next   = cmd.session;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        addr_reg <= addr_next;
        ses_reg  <= ses_next;
    end

endmodule

// ===== rtl/rnti_ip_session_map_table.sv =====
// Top level of the session map table: handshake control and the row of table cells.
// Depends on rism_pkg and rism_cell.
//
// Usage:
// The input channel (s_) carries one command per transfer: s_tuser holds the kind
// (store, address lookup, identifier lookup, remove, clear all) and s_tdata the keys.
// Every command yields exactly one result transfer on the output channel (m_), with
// the status in m_tuser and the found address or identifier in m_tdata.
// A command is served by a search token that walks the row of TABLE_ENTRIES cells,
// one cell per clock, so the first match in slot order wins. A store reserves the
// first empty slot on the way and writes it at the end of the walk if no slot matched.
// The result is registered at the end of the walk through the cell row, and the next
// command is taken only after the block has returned to idle; a new command is never
// taken while the previous one is still walking the cell row.
// A result that waits on a low m_tready stays in the output register while the next
// command is taken; a second finished result is held until the first one is taken.
// Reset empties the table at once (all valid marks clear) and drops any command in flight.
module rnti_ip_session_map_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // radio_id[15:0], address_in[47:16], session[55:48]
    input  logic [2:0]  s_tuser,  // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // address_out[31:0], radio_id_out[47:32]
    output logic [2:0]  m_tuser   // status[2:0]
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_HOLD
    } state_t;

    state_t                      state_reg, state_next;
    logic                        start_reg, start_next;
    rism_pkg::cmd_t              cmd_reg, cmd_next;
    logic                        m_valid_reg, m_valid_next;
    rism_pkg::status_t           m_status_reg, m_status_next;
    logic [rism_pkg::ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [rism_pkg::ID_W-1:0]   m_id_reg, m_id_next;
    rism_pkg::status_t           hold_status_reg, hold_status_next;
    logic [rism_pkg::ADDR_W-1:0] hold_addr_reg, hold_addr_next;
    logic [rism_pkg::ID_W-1:0]   hold_id_reg, hold_id_next;

    rism_pkg::token_t            tok_chain [0:rism_pkg::TABLE_ENTRIES];
    rism_pkg::token_t            tail;
    rism_pkg::fin_t              fin;
    rism_pkg::status_t           res_status;
    logic [rism_pkg::ADDR_W-1:0] res_addr;
    logic [rism_pkg::ID_W-1:0]   res_id;
    logic                        out_free;

    assign tok_chain[0] = '{active: start_reg, found: 1'b0, free_seen: 1'b0, data: '0};

    genvar gi;
    generate
        for (gi = 0; gi < rism_pkg::TABLE_ENTRIES; gi++) begin : g_cell
            rism_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd_reg),
                .fin     (fin),
                .tok_in  (tok_chain[gi]),
                .tok_out (tok_chain[gi+1])
            );
        end
    endgenerate

    assign tail       = tok_chain[rism_pkg::TABLE_ENTRIES];
    assign fin.done   = tail.active;
    assign fin.commit = tail.active && (cmd_reg.kind == rism_pkg::KIND_STORE)
                        && !tail.found && tail.free_seen;

    always_comb begin
        case (cmd_reg.kind)
            rism_pkg::KIND_STORE: begin
                if (tail.found) begin
                    res_status = rism_pkg::ST_UPDATED;
                end else if (tail.free_seen) begin
                    res_status = rism_pkg::ST_NEW;
                end else begin
                    res_status = rism_pkg::ST_FULL;
                end
            end
            rism_pkg::KIND_LOOKUP_ADDR,
            rism_pkg::KIND_LOOKUP_ID: begin
                res_status = tail.found ? rism_pkg::ST_FOUND : rism_pkg::ST_MISS;
            end
            rism_pkg::KIND_REMOVE: begin
                res_status = tail.found ? rism_pkg::ST_REMOVED : rism_pkg::ST_MISS;
            end
            rism_pkg::KIND_CLEAR: begin
                res_status = rism_pkg::ST_CLEARED;
            end
            default: begin
                res_status = rism_pkg::ST_MISS;
            end
        endcase
    end

    assign res_addr = (cmd_reg.kind == rism_pkg::KIND_LOOKUP_ADDR && tail.found)
                      ? tail.data : '0;
    assign res_id   = (cmd_reg.kind == rism_pkg::KIND_LOOKUP_ID && tail.found)
                      ? tail.data[rism_pkg::ID_W-1:0] : '0;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next       = state_reg;
        start_next       = 1'b0;
        cmd_next         = cmd_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_addr_next      = m_addr_reg;
        m_id_next        = m_id_reg;
        hold_status_next = hold_status_reg;
        hold_addr_next   = hold_addr_reg;
        hold_id_next     = hold_id_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next.kind     = s_tuser;
                    cmd_next.radio_id = s_tdata[15:0];
                    cmd_next.address  = s_tdata[47:16];
                    cmd_next.session  = s_tdata[55:48];
                    start_next        = 1'b1;
                    state_next        = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (tail.active) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_status_next = res_status;
                        m_addr_next   = res_addr;
                        m_id_next     = res_id;
                        state_next    = S_IDLE;
                    end else begin
                        hold_status_next = res_status;
                        hold_addr_next   = res_addr;
                        hold_id_next     = res_id;
                        state_next       = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = hold_status_reg;
                    m_addr_next   = hold_addr_reg;
                    m_id_next     = hold_id_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            start_reg       <= start_next;
            m_valid_reg     <= m_valid_next;
            cmd_reg         <= cmd_next;
            m_status_reg    <= m_status_next;
            m_addr_reg      <= m_addr_next;
            m_id_reg        <= m_id_next;
            hold_status_reg <= hold_status_next;
            hold_addr_reg   <= hold_addr_next;
            hold_id_reg     <= hold_id_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_id_reg, m_addr_reg};

endmodule

// ===== rtl/rism_checker.sv =====
// Port-level checker for the session map table, bound to the top level.
// Depends on rism_pkg and rnti_ip_session_map_table_defines.svh.
`include "rnti_ip_session_map_table_defines.svh"

module rism_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A waiting result keeps its value until the transfer completes.
    `RISM_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // The table serves one command at a time, so input is blocked right after a transfer.
    `RISM_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "input taken during a search")

    // Only a lookup hit carries data.
    `RISM_ASSERT(a_data_zero, m_tvalid && (m_tuser != rism_pkg::ST_FOUND) |-> (m_tdata == '0), "data on a result that is not a hit")

    // A hit returns either an address or an identifier, never both.
    `RISM_ASSERT(a_one_field, m_tvalid && (m_tuser == rism_pkg::ST_FOUND) |-> (m_tdata[31:0] == '0) || (m_tdata[47:32] == '0), "hit with both data fields set")

    // Status codes stay within the defined set.
    `RISM_ASSERT(a_status_range, m_tvalid |-> (m_tuser != 3'd7), "undefined status code")

endmodule

bind rnti_ip_session_map_table rism_checker u_rism_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb_rnti_ip_session_map_table.sv =====
// Self-checking testbench for the session map table: directed, table-fill, backpressure
// and random command streams, checked against a behavioral model of the table.
// Depends on rism_pkg and the rnti_ip_session_map_table RTL.
module tb_rnti_ip_session_map_table;
    timeunit 1ns;
    timeprecision 1ps;

    import rism_pkg::*;

    localparam int     CYCLE_LIMIT = 5_000_000;
    localparam int     IDLE_PCT    = 29;
    localparam int     HOLD_CYCLES = 3000;
    localparam int     RANDOM_CMDS = 740;
    localparam kind_t  KIND_UNUSED_FIRST = 3'd5;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] address;
        logic [ID_W-1:0]   radio_id;
    } lookup_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;  // radio_id[15:0], address_in[47:16], session[55:48]
    logic [2:0]  s_tuser  = '0;  // kind[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // address_out[31:0], radio_id_out[47:32]
    logic [2:0]  m_tuser;        // status[2:0]

    rnti_ip_session_map_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Behavioral copy of the table.
    bit                slot_valid [TABLE_ENTRIES];
    logic [ID_W-1:0]   slot_id    [TABLE_ENTRIES];
    logic [ADDR_W-1:0] slot_addr  [TABLE_ENTRIES];
    logic [SES_W-1:0]  slot_ses   [TABLE_ENTRIES];

    lookup_result_t pending_results[$];
    int             fail_count    = 0;
    bit             idle_ok       = 1'b1;
    int             hold_request  = 0;
    logic           hold_active   = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Verification failed");
        $finish;
    end

    // Lowest valid slot that matches identifier and session, or -1.
    function automatic int find_id_slot(logic [ID_W-1:0] id, logic [SES_W-1:0] ses);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_valid[i] && slot_id[i] == id && slot_ses[i] == ses) return i;
        end
        return -1;
    endfunction

    // Random valid slot, or -1 when the table is empty.
    function automatic int pick_live_slot();
        int live;
        int pick;
        live = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) live += slot_valid[i];
        if (live == 0) return -1;
        pick = $urandom_range(live - 1);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_valid[i]) begin
                if (pick == 0) return i;
                pick--;
            end
        end
        return -1;
    endfunction

    // Updates the table copy for one command and returns the result it must produce.
    function automatic lookup_result_t apply_command(kind_t kind, logic [ID_W-1:0] id,
                                                     logic [ADDR_W-1:0] addr,
                                                     logic [SES_W-1:0] ses);
        lookup_result_t r;
        int hit;
        int open_idx;
        r.status   = ST_MISS;
        r.address  = '0;
        r.radio_id = '0;
        case (kind)
            KIND_STORE: begin
                hit = find_id_slot(id, ses);
                if (hit >= 0) begin
                    slot_addr[hit] = addr;
                    r.status = ST_UPDATED;
                end else begin
                    open_idx = -1;
                    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                        if (!slot_valid[i]) open_idx = i;
                    end
                    if (open_idx >= 0) begin
                        slot_valid[open_idx] = 1'b1;
                        slot_id[open_idx]    = id;
                        slot_addr[open_idx]  = addr;
                        slot_ses[open_idx]   = ses;
                        r.status = ST_NEW;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
            end
            KIND_LOOKUP_ADDR: begin
                hit = find_id_slot(id, ses);
                if (hit >= 0) begin
                    r.address = slot_addr[hit];
                    r.status  = ST_FOUND;
                end
            end
            KIND_LOOKUP_ID: begin
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                    if (slot_valid[i] && slot_addr[i] == addr && slot_ses[i] == ses) begin
                        r.radio_id = slot_id[i];
                        r.status   = ST_FOUND;
                    end
                end
            end
            KIND_REMOVE: begin
                hit = find_id_slot(id, ses);
                if (hit >= 0) begin
                    slot_valid[hit] = 1'b0;
                    r.status = ST_REMOVED;
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
                r.status = ST_CLEARED;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offers one command, waits for its transfer and records the expected result.
    task automatic send_command(input kind_t kind, input logic [ID_W-1:0] id,
                                input logic [ADDR_W-1:0] addr, input logic [SES_W-1:0] ses);
        int gap;
        if (idle_ok && $urandom_range(99) < IDLE_PCT) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {ses, addr, id};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_command(kind, id, addr, ses));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Result side: checks each transfer and drives m_tready with random stalls.
    initial begin
        lookup_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result: status %0d addr %h id %h",
                                 m_tuser, m_tdata[31:0], m_tdata[47:32]);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status || m_tdata[31:0] !== want.address ||
                        m_tdata[47:32] !== want.radio_id) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: status %0d/%0d addr %h/%h id %h/%h (exp/act)",
                                     want.status, m_tuser, want.address, m_tdata[31:0],
                                     want.radio_id, m_tdata[47:32]);
                    end
                end
            end
            if (hold_active) begin
                m_tready <= 1'b0;
            end else if (idle_ok && $urandom_range(99) < IDLE_PCT) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
    initial begin
        forever begin
            wait (hold_request != 0);
            @(posedge aclk);
            hold_active <= 1'b1;
            repeat (hold_request) @(posedge aclk);
            hold_active <= 1'b0;
            hold_request = 0;
        end
    end

    task automatic test_directed();
        send_command(KIND_LOOKUP_ADDR, 16'h0000, 32'h0, 8'h00);
        send_command(KIND_LOOKUP_ID, 16'h0000, 32'h0, 8'h00);
        send_command(KIND_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_command(KIND_STORE, 16'h0000, 32'h0000_0000, 8'h00);
        send_command(KIND_STORE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_command(KIND_STORE, 16'h1234, 32'hC0A8_0001, 8'h05);
        send_command(KIND_STORE, 16'h1234, 32'hC0A8_0002, 8'h05);
        send_command(KIND_STORE, 16'h1234, 32'hC0A8_0003, 8'h06);
        send_command(KIND_LOOKUP_ADDR, 16'h1234, 32'h0, 8'h05);
        send_command(KIND_LOOKUP_ADDR, 16'hFFFF, 32'h0, 8'hFF);
        // A hit on an entry whose address is zero still reports found.
        send_command(KIND_LOOKUP_ADDR, 16'h0000, 32'hFFFF_FFFF, 8'h00);
        send_command(KIND_LOOKUP_ID, 16'h0000, 32'hC0A8_0003, 8'h06);
        send_command(KIND_LOOKUP_ID, 16'h0000, 32'hFFFF_FFFF, 8'hFF);
        send_command(KIND_LOOKUP_ID, 16'hFFFF, 32'hC0A8_0002, 8'h06);
        // Two identifiers share one address; the lower slot must win.
        send_command(KIND_STORE, 16'h5678, 32'hC0A8_0002, 8'h05);
        send_command(KIND_LOOKUP_ID, 16'h0000, 32'hC0A8_0002, 8'h05);
        send_command(KIND_REMOVE, 16'h1234, 32'h0, 8'h05);
        send_command(KIND_LOOKUP_ID, 16'h0000, 32'hC0A8_0002, 8'h05);
        send_command(KIND_REMOVE, 16'h1234, 32'h0, 8'h05);
        // The freed slot is the lowest free one and gets reused.
        send_command(KIND_STORE, 16'h9ABC, 32'h0A00_0001, 8'h00);
        for (int n = 0; n < 3; n++)
            send_command(kind_t'(KIND_UNUSED_FIRST + n), 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_command(KIND_CLEAR, 16'h0000, 32'h0, 8'h00);
        send_command(KIND_LOOKUP_ADDR, 16'hFFFF, 32'h0, 8'hFF);
        wait_results_drained();
    endtask

    // Fills every slot, then exercises a full table; the sender never idles here.
    task automatic test_table_full();
        idle_ok = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            send_command(KIND_STORE, 16'(i) ^ 16'hA5A5, $urandom, 8'($urandom_range(255)));
        send_command(KIND_STORE, 16'h0001, $urandom, 8'h00);
        send_command(KIND_STORE, slot_id[7], $urandom, slot_ses[7]);
        send_command(KIND_REMOVE, slot_id[100], 32'h0, slot_ses[100]);
        send_command(KIND_STORE, 16'h0002, $urandom, 8'h11);
        send_command(KIND_STORE, 16'h0003, $urandom, 8'h22);
        send_command(KIND_LOOKUP_ADDR, slot_id[TABLE_ENTRIES-1], 32'h0,
                     slot_ses[TABLE_ENTRIES-1]);
        send_command(KIND_LOOKUP_ID, 16'h0000, slot_addr[100], slot_ses[100]);
        send_command(KIND_LOOKUP_ID, 16'h0000, slot_addr[0], slot_ses[0]);
        send_command(KIND_CLEAR, 16'h0000, 32'h0, 8'h00);
        wait_results_drained();
        idle_ok = 1'b1;
    endtask

    // Receiver holds off while commands keep coming, so the block stalls its input.
    task automatic test_backpressure();
        idle_ok = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 14; i++)
            send_command(kind_t'(i % 3), 16'($urandom_range(3)), 32'($urandom_range(7)),
                         8'h00);
        wait_results_drained();
        idle_ok = 1'b1;
    endtask

    task automatic test_random();
        logic [ID_W-1:0]   id_pool   [8];
        logic [ADDR_W-1:0] addr_pool [8];
        logic [SES_W-1:0]  ses_pool  [4];
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr;
        logic [SES_W-1:0]  ses;
        int                pick;
        int                slot;
        for (int i = 0; i < 8; i++) begin
            id_pool[i]   = 16'($urandom);
            addr_pool[i] = $urandom;
        end
        for (int i = 0; i < 4; i++) ses_pool[i] = 8'($urandom);
        id_pool[0]   = '0;
        id_pool[1]   = '1;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        ses_pool[0]  = '0;
        ses_pool[1]  = '1;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            pick = $urandom_range(99);
            if (pick < 34)      kind = KIND_STORE;
            else if (pick < 54) kind = KIND_LOOKUP_ADDR;
            else if (pick < 72) kind = KIND_LOOKUP_ID;
            else if (pick < 88) kind = KIND_REMOVE;
            else if (pick < 91) kind = KIND_CLEAR;
            else                kind = kind_t'($urandom_range(7));
            if ($urandom_range(99) < 75) begin
                id   = id_pool[$urandom_range(7)];
                addr = addr_pool[$urandom_range(7)];
                ses  = ses_pool[$urandom_range(3)];
            end else begin
                id   = 16'($urandom);
                addr = $urandom;
                ses  = 8'($urandom);
            end
            // Most lookups and removes aim at a live entry so hits are common.
            slot = pick_live_slot();
            if (slot >= 0 && kind != KIND_STORE && $urandom_range(99) < 60) begin
                id   = slot_id[slot];
                ses  = slot_ses[slot];
                if (kind == KIND_LOOKUP_ID) addr = slot_addr[slot];
            end
            send_command(kind, id, addr, ses);
        end
        wait_results_drained();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random();
        repeat (TABLE_ENTRIES + 16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
